// File: rtl/spsc_pkg.sv
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared widths, reset values, datapath codes and the microcode table of the
// speed PI and steering P controller.
// ----------------------------------------------------------------------------
package spsc_pkg;

   // Fixed-point fraction of all speed quantities
   localparam int FRAC_BITS = 10;

   // Field widths
   localparam int CAP_W     = 16;
   localparam int TGT_W     = 16;
   localparam int GAIN_W    = 10;
   localparam int DIST_W    = 16;
   localparam int MID_W     = 16;
   localparam int KPS_W     = 8;
   localparam int BASE_W    = 12;
   localparam int SERVO_W   = 11;
   localparam int MOTOR_W   = 12;
   localparam int SPEED_W   = DIST_W + FRAC_BITS;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 16;

   // Internal widths
   localparam int STEER_W   = CAP_W + 2;
   localparam int ERR_W     = SPEED_W + 1;
   localparam int INTEG_W   = 32;
   localparam int MUL_A_W   = GAIN_W + 1;
   localparam int MUL_B_W   = INTEG_W + 1;
   localparam int ACC_W     = MUL_A_W + MUL_B_W;
   localparam int DIV_CNT_W = $clog2(SPEED_W);
   localparam int STEP_W    = 4;

   // Constants of the control laws
   localparam int CAP_MAX         = 65535;
   localparam int SERVO_CENTER    = 1500;
   localparam int SERVO_MIN       = 1000;
   localparam int SERVO_MAX       = 2000;
   localparam int MOTOR_MIN       = 500;
   localparam int MOTOR_MAX       = 2500;
   localparam int MOTOR_RESET     = 1000;
   localparam int BOOST_THRESHOLD = 200;

   // Register reset values
   localparam int TARGET_RESET = 4096;
   localparam int KP_SPD_RESET = 100;
   localparam int KI_SPD_RESET = 15;
   localparam int DIST_RESET   = 1256;
   localparam int MID_RESET    = 120;
   localparam int KP_STR_RESET = 10;
   localparam int BASE_N_RESET = 1000;
   localparam int BASE_B_RESET = 1500;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_SPEED    = 4'd0,
      CSR_KP_SPEED        = 4'd1,
      CSR_KI_SPEED        = 4'd2,
      CSR_DISTANCE_SCALE  = 4'd3,
      CSR_MIDDLE_LINE     = 4'd4,
      CSR_KP_STEERING     = 4'd5,
      CSR_BASE_PWM_NORMAL = 4'd6,
      CSR_BASE_PWM_BOOST  = 4'd7
   } csr_index_type;

   // Event kinds
   localparam logic ACTION_STEER = 1'b0;
   localparam logic ACTION_SPEED = 1'b1;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_STEER_ERR,
      OP_SERVO_SUM,
      OP_SERVO_CLAMP,
      OP_PERIOD,
      OP_DIV_STEP,
      OP_SPEED_ERR,
      OP_INTEG,
      OP_BASE_ADD,
      OP_ACC_ADD,
      OP_MOTOR_CLAMP
   } op_type;

   // Multiplier operand selection
   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_KP_STEER,
      MUL_KP_SPEED,
      MUL_KI_SPEED
   } mul_sel_type;

   // Sequencing
   typedef enum logic [1:0] {
      COND_NEXT,
      COND_JUMP,
      COND_DIV_LOOP
   } cond_type;

   typedef logic [STEP_W-1:0] step_type;

   typedef struct packed {
      op_type      op;
      mul_sel_type mul;
      cond_type    cond;
      step_type    target;
      logic        last;
   } ctrl_word_type;

   // Program entry points
   localparam step_type STEP_STEER = 4'd0;
   localparam step_type STEP_SPEED = 4'd4;
   localparam step_type STEP_DIV   = 4'd5;
   localparam step_type STEP_DONE  = 4'd11;

   // Microcode table
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w = '{op: OP_NONE, mul: MUL_NONE, cond: COND_NEXT, target: STEP_DONE, last: 1'b1};
      case (step)
         4'd0:  w = '{OP_STEER_ERR,   MUL_NONE,     COND_NEXT,     STEP_DONE, 1'b0};
         4'd1:  w = '{OP_NONE,        MUL_KP_STEER, COND_NEXT,     STEP_DONE, 1'b0};
         4'd2:  w = '{OP_SERVO_SUM,   MUL_NONE,     COND_NEXT,     STEP_DONE, 1'b0};
         4'd3:  w = '{OP_SERVO_CLAMP, MUL_NONE,     COND_JUMP,     STEP_DONE, 1'b0};
         4'd4:  w = '{OP_PERIOD,      MUL_NONE,     COND_NEXT,     STEP_DONE, 1'b0};
         4'd5:  w = '{OP_DIV_STEP,    MUL_NONE,     COND_DIV_LOOP, STEP_DIV,  1'b0};
         4'd6:  w = '{OP_SPEED_ERR,   MUL_NONE,     COND_NEXT,     STEP_DONE, 1'b0};
         4'd7:  w = '{OP_INTEG,       MUL_KP_SPEED, COND_NEXT,     STEP_DONE, 1'b0};
         4'd8:  w = '{OP_BASE_ADD,    MUL_KI_SPEED, COND_NEXT,     STEP_DONE, 1'b0};
         4'd9:  w = '{OP_ACC_ADD,     MUL_NONE,     COND_NEXT,     STEP_DONE, 1'b0};
         4'd10: w = '{OP_MOTOR_CLAMP, MUL_NONE,     COND_NEXT,     STEP_DONE, 1'b0};
         4'd11: w = '{OP_NONE,        MUL_NONE,     COND_NEXT,     STEP_DONE, 1'b1};
         default: w = '{OP_NONE,      MUL_NONE,     COND_NEXT,     STEP_DONE, 1'b1};
      endcase
      return w;
   endfunction

endpackage

// File: rtl/speed_pi_and_steering_p_controller_top.sv
// ----------------------------------------------------------------------------
// speed_pi_and_steering_p_controller_top
// Steering P loop and wheel-speed PI loop run by a microcoded sequencer over
// one shared multiplier, an accumulator and a restoring divider.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel is one capture event and yields one result
// on the rsp_ channel carrying the held servo compare, motor compare and
// speed. A line-sync event runs a 5-step program; a wheel event runs 33
// steps, 26 of which are the one-bit-per-cycle division of the scaled
// distance by the pulse period. One event is worked on at a time; the next
// is taken as soon as the program of the previous one has handed its result
// to the output register, even while that result still waits to be taken.
// Register writes on the csr_ channel are always accepted and are meant to
// happen while the block is idle.
module speed_pi_and_steering_p_controller_top (
   input  logic                             clock,
   input  logic                             reset,
   // Register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [spsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spsc_pkg::CSR_DAT_W-1:0]   csr_wdata,
   // Event channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_action,
   input  logic [spsc_pkg::CAP_W-1:0]       req_capture,
   // Result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [spsc_pkg::SERVO_W-1:0]     rsp_servo_compare,
   output logic [spsc_pkg::MOTOR_W-1:0]     rsp_motor_compare,
   output logic [spsc_pkg::SPEED_W-1:0]     rsp_speed_q10
);
   import spsc_pkg::*;

   localparam logic signed [ACC_W-1:0] SERVO_LO = ACC_W'(SERVO_MIN);
   localparam logic signed [ACC_W-1:0] SERVO_HI = ACC_W'(SERVO_MAX);
   localparam logic signed [ACC_W-1:0] MOTOR_LO = ACC_W'(MOTOR_MIN) << FRAC_BITS;
   localparam logic signed [ACC_W-1:0] MOTOR_HI = ACC_W'(MOTOR_MAX) << FRAC_BITS;
   localparam logic signed [STEER_W-1:0] BOOST_LIM = STEER_W'(BOOST_THRESHOLD);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SPEED_W - 1);

   // Configuration registers
   logic [TGT_W-1:0]  target_ff;
   logic [GAIN_W-1:0] kp_spd_ff;
   logic [GAIN_W-1:0] ki_spd_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [MID_W-1:0]  mid_ff;
   logic [KPS_W-1:0]  kp_str_ff;
   logic [BASE_W-1:0] base_n_ff;
   logic [BASE_W-1:0] base_b_ff;

   // Sequencer
   logic          busy_ff;
   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type uw;
   logic          req_fire;
   logic          deliver;

   // Datapath state
   logic [CAP_W-1:0]          cap_ff;
   logic [CAP_W-1:0]          last_cap_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [STEER_W-1:0] steer_err_ff;
   logic                      boost_ff;
   logic [SERVO_W-1:0]        servo_ff;
   logic [MOTOR_W-1:0]        motor_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   prod_ff;
   logic [CAP_W-1:0]          divisor_ff;
   logic [CAP_W-1:0]          rem_ff;
   logic [SPEED_W-1:0]        quot_ff;
   logic [DIV_CNT_W-1:0]      div_cnt_ff;

   // Output register
   logic               rsp_valid_ff;
   logic [SERVO_W-1:0] rsp_servo_ff;
   logic [MOTOR_W-1:0] rsp_motor_ff;
   logic [SPEED_W-1:0] rsp_speed_ff;

   // Combinational helpers
   logic [CAP_W:0]            period_diff;
   logic [CAP_W-1:0]          period;
   logic [CAP_W:0]            rem_sh;
   logic                      rem_ge;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [ACC_W-1:0]   mul_p;
   logic signed [INTEG_W:0]   integ_sum;
   logic [BASE_W-1:0]         base_sel;

   assign csr_ready         = 1'b1;
   assign req_ready         = !busy_ff;
   assign req_fire          = req_valid && req_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_servo_compare = rsp_servo_ff;
   assign rsp_motor_compare = rsp_motor_ff;
   assign rsp_speed_q10     = rsp_speed_ff;

   // Fetch the control word of the current step
   assign uw      = ucode_rom(step_ff);
   assign deliver = busy_ff && uw.last && (!rsp_valid_ff || rsp_ready);

   // Pick the next step
   always_comb begin
      step_in = step_ff + 1'b1;
      case (uw.cond)
         COND_JUMP:     step_in = uw.target;
         COND_DIV_LOOP: if (div_cnt_ff != DIV_LAST) begin
            step_in = uw.target;
         end
         default:       step_in = step_ff + 1'b1;
      endcase
   end

   // Wrapped period of the down-counting timer, zero taken as one
   always_comb begin
      period_diff = {1'b0, last_cap_ff} - {1'b0, cap_ff};
      if (cap_ff <= last_cap_ff) begin
         period = period_diff[CAP_W-1:0];
      end else begin
         period = period_diff[CAP_W-1:0] - 1'b1;
      end
      if (period == '0) begin
         period = CAP_W'(1);
      end
   end

   // One restoring division step
   assign rem_sh = {rem_ff, quot_ff[SPEED_W-1]};
   assign rem_ge = rem_sh >= {1'b0, divisor_ff};

   // Shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (uw.mul)
         MUL_KP_STEER: begin
            mul_a = MUL_A_W'(kp_str_ff);
            mul_b = MUL_B_W'(steer_err_ff);
         end
         MUL_KP_SPEED: begin
            mul_a = MUL_A_W'(kp_spd_ff);
            mul_b = MUL_B_W'(err_ff);
         end
         MUL_KI_SPEED: begin
            mul_a = MUL_A_W'(ki_spd_ff);
            mul_b = MUL_B_W'(integ_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Saturating integral
   always_comb begin
      integ_sum = $signed({integ_ff[INTEG_W-1], integ_ff}) + (INTEG_W+1)'(err_ff);
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_in = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end
   end

   assign base_sel = boost_ff ? base_b_ff : base_n_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TGT_W'(TARGET_RESET);
         kp_spd_ff <= GAIN_W'(KP_SPD_RESET);
         ki_spd_ff <= GAIN_W'(KI_SPD_RESET);
         dist_ff   <= DIST_W'(DIST_RESET);
         mid_ff    <= MID_W'(MID_RESET);
         kp_str_ff <= KPS_W'(KP_STR_RESET);
         base_n_ff <= BASE_W'(BASE_N_RESET);
         base_b_ff <= BASE_W'(BASE_B_RESET);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TARGET_SPEED:    target_ff <= csr_wdata[TGT_W-1:0];
            CSR_KP_SPEED:        kp_spd_ff <= csr_wdata[GAIN_W-1:0];
            CSR_KI_SPEED:        ki_spd_ff <= csr_wdata[GAIN_W-1:0];
            CSR_DISTANCE_SCALE:  dist_ff   <= csr_wdata[DIST_W-1:0];
            CSR_MIDDLE_LINE:     mid_ff    <= csr_wdata[MID_W-1:0];
            CSR_KP_STEERING:     kp_str_ff <= csr_wdata[KPS_W-1:0];
            CSR_BASE_PWM_NORMAL: base_n_ff <= csr_wdata[BASE_W-1:0];
            CSR_BASE_PWM_BOOST:  base_b_ff <= csr_wdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_STEER;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (deliver) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            busy_ff <= 1'b1;
            step_ff <= (req_action == ACTION_SPEED) ? STEP_SPEED : STEP_STEER;
         end else if (busy_ff) begin
            if (uw.last) begin
               // hold at the last step until the output register is free
               if (deliver) begin
                  busy_ff <= 1'b0;
               end
            end else begin
               step_ff <= step_in;
            end
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (deliver) begin
         rsp_servo_ff <= servo_ff;
         rsp_motor_ff <= motor_ff;
         rsp_speed_ff <= quot_ff;
      end
   end

   // Controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_cap_ff  <= CAP_W'(CAP_MAX);
         integ_ff     <= '0;
         steer_err_ff <= '0;
         boost_ff     <= 1'b0;
         servo_ff     <= SERVO_W'(SERVO_CENTER);
         motor_ff     <= MOTOR_W'(MOTOR_RESET);
         quot_ff      <= '0;
      end else if (busy_ff) begin
         case (uw.op)
            OP_STEER_ERR: begin
               steer_err_ff <= $signed(STEER_W'(mid_ff) + STEER_W'(cap_ff)
                                       - STEER_W'(CAP_MAX));
            end
            OP_SERVO_CLAMP: begin
               if (acc_ff < SERVO_LO) begin
                  servo_ff <= SERVO_W'(SERVO_MIN);
               end else if (acc_ff > SERVO_HI) begin
                  servo_ff <= SERVO_W'(SERVO_MAX);
               end else begin
                  servo_ff <= acc_ff[SERVO_W-1:0];
               end
            end
            OP_PERIOD: begin
               // load the scaled distance as dividend
               quot_ff <= SPEED_W'(dist_ff) << FRAC_BITS;
            end
            OP_DIV_STEP: begin
               quot_ff <= {quot_ff[SPEED_W-2:0], rem_ge};
            end
            OP_INTEG: begin
               integ_ff <= integ_in;
               if (steer_err_ff > BOOST_LIM) begin
                  boost_ff <= 1'b1;
               end
            end
            OP_MOTOR_CLAMP: begin
               if (acc_ff < MOTOR_LO) begin
                  motor_ff <= MOTOR_W'(MOTOR_MIN);
               end else if (acc_ff > MOTOR_HI) begin
                  motor_ff <= MOTOR_W'(MOTOR_MAX);
               end else begin
                  motor_ff <= acc_ff[FRAC_BITS +: MOTOR_W];
               end
               last_cap_ff <= cap_ff;
            end
            default: ;
         endcase
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cap_ff <= req_capture;
      end
      if (busy_ff) begin
         prod_ff <= mul_p;
         case (uw.op)
            OP_SERVO_SUM: acc_ff <= ACC_W'(SERVO_CENTER) + prod_ff;
            OP_PERIOD: begin
               divisor_ff <= period;
               rem_ff     <= '0;
               div_cnt_ff <= '0;
            end
            OP_DIV_STEP: begin
               rem_ff     <= rem_ge ? CAP_W'(rem_sh - {1'b0, divisor_ff})
                                    : rem_sh[CAP_W-1:0];
               div_cnt_ff <= div_cnt_ff + 1'b1;
            end
            OP_SPEED_ERR: err_ff <= $signed(ERR_W'(target_ff) - ERR_W'(quot_ff));
            OP_BASE_ADD:  acc_ff <= $signed(ACC_W'(base_sel) << FRAC_BITS) + prod_ff;
            OP_ACC_ADD:   acc_ff <= acc_ff + prod_ff;
            default: ;
         endcase
      end
   end

endmodule
